// ===== design/move_to_front_codec_defines.svh =====
// Assertion macros for the move-to-front codec, used by mtf_ctrl.
// No dependencies; expects clk and rst_n in the scope of each use.
`ifndef MOVE_TO_FRONT_CODEC_DEFINES_SVH
`define MOVE_TO_FRONT_CODEC_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define MTF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MTF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mtf_pkg.sv =====
// Shared types and constants for the move-to-front codec.
// No dependencies; used by mtf_cell, mtf_ctrl and move_to_front_codec.
package mtf_pkg;

  localparam int NUM_CELLS = 256;
  localparam int SYM_W     = 8;

  typedef logic [SYM_W-1:0] sym_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_INJECT,
    CMD_SHIFT,
    CMD_IDENT
  } cmd_op_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    cmd_op_t op;
    sym_t    key;   // search symbol (encode) or list position (decode)
    sym_t    sym;   // symbol entering the front on a shift
  } cmd_t;

  // Forward wave used for encoding.
  typedef struct packed {
    logic vld;
    logic found;
    sym_t data;
    sym_t pos;
  } fwd_t;

  // Backward lane used for decoding.
  typedef struct packed {
    logic vld;
    sym_t data;
  } lane_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENC_START,
    S_ENC_WAIT,
    S_DEC_START,
    S_DEC_WAIT,
    S_FIN
  } state_t;

endpackage

// ===== design/mtf_cell.sv =====
// One entry of the recency list with its wave and lane stages.
// Depends on mtf_pkg.
module mtf_cell #(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  mtf_pkg::cmd_t  cmd,
  input  mtf_pkg::sym_t  prev_val,
  output mtf_pkg::sym_t  val,
  input  mtf_pkg::fwd_t  fwd_in,
  output mtf_pkg::fwd_t  fwd_out,
  input  mtf_pkg::lane_t lane_in,
  output mtf_pkg::lane_t lane_out
);

  localparam mtf_pkg::sym_t IDX_L = mtf_pkg::SYM_W'(IDX);

  mtf_pkg::sym_t  val_r, val_nxt;
  mtf_pkg::fwd_t  fwd_r, fwd_nxt;
  mtf_pkg::lane_t lane_r, lane_nxt;
  logic           live;
  logic           hit;

  always_comb begin
    live = fwd_in.vld && !fwd_in.found;
    hit  = live && (val_r == cmd.key);

    val_nxt = val_r;
    if (cmd.op == mtf_pkg::CMD_IDENT) begin
      val_nxt = IDX_L;
    end else if (cmd.op == mtf_pkg::CMD_SHIFT && IDX_L <= cmd.key) begin
      val_nxt = prev_val;
    end else if (live) begin
      val_nxt = fwd_in.data;
    end

    fwd_nxt.vld   = fwd_in.vld;
    fwd_nxt.found = fwd_in.found | hit;
    fwd_nxt.data  = val_r;
    fwd_nxt.pos   = hit ? IDX_L : fwd_in.pos;

    if (cmd.op == mtf_pkg::CMD_INJECT && cmd.key == IDX_L) begin
      lane_nxt.vld  = 1'b1;
      lane_nxt.data = val_r;
    end else begin
      lane_nxt = lane_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r  <= IDX_L;
      fwd_r  <= '0;
      lane_r <= '0;
    end else begin
      val_r  <= val_nxt;
      fwd_r  <= fwd_nxt;
      lane_r <= lane_nxt;
    end
  end

  assign val      = val_r;
  assign fwd_out  = fwd_r;
  assign lane_out = lane_r;

endmodule

// ===== design/mtf_ctrl.sv =====
// Sequencer: handshakes, mode register, command broadcast, result register.
// Depends on mtf_pkg and move_to_front_codec_defines.svh.
`include "move_to_front_codec_defines.svh"

module mtf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  mtf_pkg::sym_t  in_byte,
  input  logic           in_block_end,
  output logic           out_valid,
  input  logic           out_ready,
  output mtf_pkg::sym_t  out_byte,
  output logic           out_last,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_decode_mode,
  output mtf_pkg::cmd_t  cmd,
  output mtf_pkg::fwd_t  fwd_head,
  input  mtf_pkg::fwd_t  fwd_tail,
  input  mtf_pkg::lane_t lane_head
);

  mtf_pkg::state_t state_r, state_nxt;
  mtf_pkg::sym_t   key_r;
  logic            last_r;
  mtf_pkg::sym_t   res_r, res_nxt;
  logic            decode_mode_r;
  logic            out_valid_r;
  mtf_pkg::sym_t   out_byte_r;
  logic            out_last_r;
  logic            out_load;
  logic            in_accept;

  assign in_ready  = (state_r == mtf_pkg::S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    out_load  = 1'b0;
    cmd.op    = mtf_pkg::CMD_NONE;
    cmd.key   = key_r;
    cmd.sym   = lane_head.data;
    fwd_head  = '0;
    case (state_r)
      mtf_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = decode_mode_r ? mtf_pkg::S_DEC_START : mtf_pkg::S_ENC_START;
        end
      end
      mtf_pkg::S_ENC_START: begin
        fwd_head.vld  = 1'b1;
        fwd_head.data = key_r;
        state_nxt     = mtf_pkg::S_ENC_WAIT;
      end
      mtf_pkg::S_ENC_WAIT: begin
        if (fwd_tail.vld) begin
          res_nxt   = fwd_tail.found ? fwd_tail.pos : '0;
          state_nxt = mtf_pkg::S_FIN;
        end
      end
      mtf_pkg::S_DEC_START: begin
        cmd.op    = mtf_pkg::CMD_INJECT;
        state_nxt = mtf_pkg::S_DEC_WAIT;
      end
      mtf_pkg::S_DEC_WAIT: begin
        if (lane_head.vld) begin
          res_nxt   = lane_head.data;
          cmd.op    = mtf_pkg::CMD_SHIFT;
          state_nxt = mtf_pkg::S_FIN;
        end
      end
      mtf_pkg::S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = mtf_pkg::S_IDLE;
          if (last_r) begin
            cmd.op = mtf_pkg::CMD_IDENT;
          end
        end
      end
      default: begin
        state_nxt = mtf_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= mtf_pkg::S_IDLE;
      decode_mode_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        decode_mode_r <= cfg_decode_mode;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (in_accept) begin
      key_r  <= in_byte;
      last_r <= in_block_end;
    end
    if (out_load) begin
      out_byte_r <= res_r;
      out_last_r <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  `MTF_ASSERT_NOW(a_wave_end_in_wait, fwd_tail.vld, state_r == mtf_pkg::S_ENC_WAIT, "encode wave left the row outside its wait state")
  `MTF_ASSERT_NOW(a_wave_always_hits, fwd_tail.vld, fwd_tail.found, "symbol missing from recency list")
  `MTF_ASSERT_NOW(a_lane_in_wait, lane_head.vld, state_r == mtf_pkg::S_DEC_WAIT, "decode lane arrived outside its wait state")
  `MTF_ASSERT_NEXT(a_accept_starts, in_accept, state_r == mtf_pkg::S_ENC_START || state_r == mtf_pkg::S_DEC_START, "accepted transaction did not start")

endmodule

// ===== design/move_to_front_codec.sv =====
// Byte move-to-front encoder/decoder: top level, a row of list cells plus sequencer.
// Depends on mtf_pkg, mtf_cell and mtf_ctrl.
//
// Usage
//   Input channel (in_valid/in_ready): one byte per transaction plus a block-end
//   flag. Output channel (out_valid/out_ready): one byte per input transaction,
//   out_last copying the block-end flag. Config channel (cfg_valid/cfg_ready,
//   always ready) sets decode mode; write it only while the codec is idle.
//   Throughput: one transaction at a time; the next input is taken the cycle after
//   the result enters the output register. Encode time is set by the search wave
//   walking all 256 cells one per cycle; decode time by the lane carrying the
//   symbol back from its position to the head of the row.
//   Reset: synchronous, active low; the list returns to the identity and encode
//   mode is selected. A block-end transaction reloads the identity as its result
//   is handed to the output register.
//   Stall: the output register holds the result while out_ready is low; a new
//   input may be accepted and processed meanwhile, and waits only at the final
//   hand-over if the register is still occupied.
module move_to_front_codec (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_block_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_decode_mode
);

  localparam int LAST = mtf_pkg::NUM_CELLS - 1;

  // Broadcast command, and the chain links between neighbouring cells.
  mtf_pkg::cmd_t  cmd;
  mtf_pkg::fwd_t  fwd_head;
  mtf_pkg::sym_t  val_w  [mtf_pkg::NUM_CELLS];
  mtf_pkg::fwd_t  fwd_w  [mtf_pkg::NUM_CELLS];
  mtf_pkg::lane_t lane_w [mtf_pkg::NUM_CELLS];

  mtf_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_block_end    (in_block_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_decode_mode (cfg_decode_mode),
    .cmd             (cmd),
    .fwd_head        (fwd_head),
    .fwd_tail        (fwd_w[LAST]),
    .lane_head       (lane_w[0])
  );

  // Cell k holds list entry k. The encode wave runs head to tail, the decode
  // lane tail to head; a shift moves every entry up to the position back one.
  for (genvar k = 0; k < mtf_pkg::NUM_CELLS; k++) begin : g_cell
    mtf_pkg::sym_t  prev_val;
    mtf_pkg::fwd_t  fwd_in;
    mtf_pkg::lane_t lane_in;

    if (k == 0) begin : g_head
      assign prev_val = cmd.sym;
      assign fwd_in   = fwd_head;
    end else begin : g_body
      assign prev_val = val_w[k-1];
      assign fwd_in   = fwd_w[k-1];
    end

    if (k == LAST) begin : g_tail
      assign lane_in = '0;
    end else begin : g_link
      assign lane_in = lane_w[k+1];
    end

    mtf_cell #(
      .IDX (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .prev_val (prev_val),
      .val      (val_w[k]),
      .fwd_in   (fwd_in),
      .fwd_out  (fwd_w[k]),
      .lane_in  (lane_in),
      .lane_out (lane_w[k])
    );
  end

endmodule
